### src/mrc_pkg.sv
// Package for the Modbus RTU response checker.
// Holds the shared types, codes, constants and the byte-wise CRC-16 update.
// No dependencies.
package mrc_pkg;

  localparam int unsigned MAX_REGS = 125;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  EXC_FLAG_MASK = 8'h80;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'd3;
  localparam logic [7:0]  FUNC_WRITE_MULTIPLE = 8'd16;
  localparam logic [8:0]  MIN_FRAME_LEN = 9'd5;
  localparam logic [8:0]  WRITE_FRAME_LEN = 9'd8;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SLAVE_ADDRESS     = 2'd0,
    REG_WRITE_MODE        = 2'd1,
    REG_EXPECTED_START    = 2'd2,
    REG_EXPECTED_QUANTITY = 2'd3
  } mrc_reg_idx_t;

  // Frame status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EXCEPTION = 2'd1,
    STATUS_MISMATCH  = 2'd2,
    STATUS_CRC_ERROR = 2'd3
  } mrc_status_t;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic        write_mode;
    logic [15:0] expected_start;
    logic [6:0]  expected_quantity;
  } mrc_cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } mrc_item_t;

  // CRC-16/Modbus update by one byte, eight reflected shift steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

### src/mrc_if.sv
// Channel interfaces for the Modbus RTU response checker.
// Input byte stream, result stream and configuration write channel.
// Depends on nothing.
interface mrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       restart;
  modport source (output valid, rx_byte, restart, input ready);
  modport sink   (input valid, rx_byte, restart, output ready);
endinterface

interface mrc_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload;
  logic [1:0] status;
  logic [7:0] exception_code;
  modport source (output valid, kind, payload, status, exception_code, input ready);
  modport sink   (input valid, kind, payload, status, exception_code, output ready);
endinterface

interface mrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/mrc_cfg_regs.sv
// Configuration register file of the response checker.
// Depends on mrc_pkg and mrc_cfg_if.
module mrc_cfg_regs
  import mrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  mrc_cfg_if.sink    cfg,
  output mrc_cfg_t   regs
);

  assign cfg.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.slave_address     <= 8'd1;
      regs.write_mode        <= 1'b0;
      regs.expected_start    <= 16'd0;
      regs.expected_quantity <= 7'd0;
    end else if (cfg.valid) begin
      unique case (mrc_reg_idx_t'(cfg.index))
        REG_SLAVE_ADDRESS:     regs.slave_address     <= cfg.data[7:0];
        REG_WRITE_MODE:        regs.write_mode        <= cfg.data[0];
        REG_EXPECTED_START:    regs.expected_start    <= cfg.data;
        REG_EXPECTED_QUANTITY: regs.expected_quantity <= cfg.data[6:0];
      endcase
    end
  end

endmodule

### src/mrc_in_reg.sv
// Input register stage: captures one received byte per request.
// Depends on mrc_pkg and mrc_in_if.
module mrc_in_reg
  import mrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  mrc_in_if.sink    rx,
  input  logic      take,
  output logic      item_valid,
  output mrc_item_t item
);

  // Free slot, or the held byte leaves this cycle
  assign rx.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (rx.ready) begin
      item_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      item.rx_byte <= rx.rx_byte;
      item.restart <= rx.restart;
    end
  end

endmodule

### src/mrc_frame_core.sv
// Frame state, CRC check and result register of the response checker.
// Depends on mrc_pkg and mrc_out_if.
module mrc_frame_core
  import mrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  mrc_cfg_t  cfg,
  input  logic      item_valid,
  input  mrc_item_t item,
  output logic      take,
  mrc_out_if.source res
);

  logic [8:0]  byte_position, byte_position_next;
  logic [8:0]  frame_length, frame_length_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  seen_id, seen_id_next;
  logic [7:0]  seen_function, seen_function_next;
  logic [7:0]  seen_exception, seen_exception_next;
  logic [31:0] echo_fields, echo_fields_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;

  logic [8:0]  pos_eff, flen_eff;
  logic [15:0] crc_eff;
  logic [31:0] echo_eff;
  logic [9:0]  pos_w, flen_w;
  logic        in_body, at_crc_low;
  logic        emit, emit_kind;
  logic [7:0]  emit_payload, emit_code;
  mrc_status_t emit_status;
  logic [15:0] got_crc;

  assign take = item_valid && (!res.valid || res.ready);

  // Per-byte frame logic
  always_comb begin
    pos_eff  = item.restart ? 9'd0 : byte_position;
    flen_eff = item.restart ? MIN_FRAME_LEN : frame_length;
    crc_eff  = item.restart ? CRC_INIT : running_crc;
    echo_eff = item.restart ? 32'd0 : echo_fields;
    pos_w    = {1'b0, pos_eff} + 10'd2;
    flen_w   = {1'b0, flen_eff};
    in_body    = pos_w < flen_w;
    at_crc_low = pos_w == flen_w;
    got_crc    = {item.rx_byte, crc_low_byte};

    byte_position_next  = pos_eff + 9'd1;
    frame_length_next   = flen_eff;
    running_crc_next    = crc_eff;
    echo_fields_next    = echo_eff;
    seen_id_next        = seen_id;
    seen_function_next  = seen_function;
    seen_exception_next = seen_exception;
    crc_low_byte_next   = crc_low_byte;

    emit         = 1'b0;
    emit_kind    = KIND_DATA;
    emit_payload = 8'd0;
    emit_status  = STATUS_OK;
    emit_code    = 8'd0;

    if (in_body) begin
      running_crc_next = crc16_byte(crc_eff, item.rx_byte);
      if (pos_eff == 9'd0) begin
        seen_id_next = item.rx_byte;
      end else if (pos_eff == 9'd1) begin
        seen_function_next = item.rx_byte;
      end else if (pos_eff == 9'd2) begin
        if ((seen_function & EXC_FLAG_MASK) != 8'd0) begin
          seen_exception_next = item.rx_byte;
          frame_length_next   = MIN_FRAME_LEN;
        end else if (cfg.write_mode) begin
          frame_length_next = WRITE_FRAME_LEN;
        end else begin
          frame_length_next = MIN_FRAME_LEN + {1'b0, item.rx_byte};
        end
      end
      // Echoed address and quantity, bytes two to five
      if (pos_eff >= 9'd2 && pos_eff <= 9'd5) begin
        echo_fields_next = {echo_eff[23:0], item.rx_byte};
      end
      // Read data forwarded before validation
      if (pos_eff >= 9'd3 && !cfg.write_mode &&
          (seen_function & EXC_FLAG_MASK) == 8'd0) begin
        emit         = 1'b1;
        emit_payload = item.rx_byte;
      end
    end else if (at_crc_low) begin
      crc_low_byte_next = item.rx_byte;
    end else begin
      // Last byte: status, then a fresh frame
      emit      = 1'b1;
      emit_kind = KIND_STATUS;
      if (got_crc != crc_eff) begin
        emit_status = STATUS_CRC_ERROR;
      end else if ((seen_function & EXC_FLAG_MASK) != 8'd0) begin
        if (seen_exception != 8'd0) begin
          emit_status = STATUS_EXCEPTION;
          emit_code   = seen_exception;
        end else begin
          emit_status = STATUS_MISMATCH;
        end
      end else if (seen_id != cfg.slave_address) begin
        emit_status = STATUS_MISMATCH;
      end else if (cfg.write_mode) begin
        if (seen_function != FUNC_WRITE_MULTIPLE ||
            echo_fields[31:16] != cfg.expected_start ||
            echo_fields[15:0] != {9'd0, cfg.expected_quantity} ||
            {25'd0, cfg.expected_quantity} > MAX_REGS) begin
          emit_status = STATUS_MISMATCH;
        end
      end else if (seen_function != FUNC_READ_HOLDING) begin
        emit_status = STATUS_MISMATCH;
      end
      byte_position_next = 9'd0;
      frame_length_next  = MIN_FRAME_LEN;
      running_crc_next   = CRC_INIT;
      echo_fields_next   = 32'd0;
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= 9'd0;
      frame_length   <= MIN_FRAME_LEN;
      running_crc    <= CRC_INIT;
      seen_id        <= 8'd0;
      seen_function  <= 8'd0;
      seen_exception <= 8'd0;
      echo_fields    <= 32'd0;
      crc_low_byte   <= 8'd0;
    end else if (take) begin
      byte_position  <= byte_position_next;
      frame_length   <= frame_length_next;
      running_crc    <= running_crc_next;
      seen_id        <= seen_id_next;
      seen_function  <= seen_function_next;
      seen_exception <= seen_exception_next;
      echo_fields    <= echo_fields_next;
      crc_low_byte   <= crc_low_byte_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (take) begin
      res.valid <= emit;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res.kind           <= emit_kind;
      res.payload        <= emit_payload;
      res.status         <= emit_status;
      res.exception_code <= emit_code;
    end
  end

  // Checks
  a_flen_min: assert property (@(posedge clk) disable iff (rst)
    frame_length >= MIN_FRAME_LEN)
    else $error("frame length below minimum");

  // The last byte of a frame sits at position frame_length - 1
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, byte_position} + 10'd1) <= {1'b0, frame_length})
    else $error("byte position ran past frame end");

  a_status_restarts: assert property (@(posedge clk) disable iff (rst)
    take && emit && emit_kind == KIND_STATUS |=> byte_position == 9'd0)
    else $error("frame not restarted after status");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == KIND_DATA |-> res.status == STATUS_OK &&
    res.exception_code == 8'd0)
    else $error("data result carries status bits");

  a_code_only_exc: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.exception_code != 8'd0 |-> res.status == STATUS_EXCEPTION)
    else $error("exception code without exception status");

endmodule

### src/modbus_rtu_response_checker.sv
// Modbus RTU response checker, master side. Accepts one received byte per
// request on rx and sustains one byte per clock while res is not stalled; a
// byte's result reaches res through the input register, then the frame
// state update into the result register. A result held on res stalls the
// input register and so rx. The per-cycle path is the byte-wise CRC-16
// update, eight reflected shift steps. Read data bytes are forwarded before
// the frame is checked, so drop them on any status other than ok. Write cfg
// only between bytes with no result outstanding.
// Depends on mrc_pkg, mrc_if, mrc_cfg_regs, mrc_in_reg and mrc_frame_core.
module modbus_rtu_response_checker
  import mrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  mrc_in_if.sink    rx,
  mrc_out_if.source res,
  mrc_cfg_if.sink   cfg
);

  mrc_cfg_t  regs;
  mrc_item_t item;
  logic      item_valid;
  logic      take;

  mrc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  mrc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  mrc_frame_core u_frame_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (regs),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .res        (res)
  );

endmodule

### verif/mrc_frame_checker.sv
// Frame checker for the Modbus RTU response checker testbench.
// Watches the byte, result and configuration channels, predicts each result
// and compares it with what the block returns. Depends on mrc_pkg and mrc_if.
module mrc_frame_checker
  import mrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  mrc_in_if                rx,
  mrc_out_if               res,
  mrc_cfg_if               cfg,
  output int unsigned      failures,
  output int unsigned      awaiting,
  output int unsigned      data_bytes_seen,
  output logic [3:0][31:0] status_tally
);

  typedef struct packed {
    logic       kind;
    logic [7:0] payload;
    logic [1:0] status;
    logic [7:0] code;
  } frame_result_t;

  frame_result_t awaited_results [$];

  // Shadow of the configuration registers
  mrc_cfg_t shadow;

  // Frame tracking state
  int unsigned pos;
  int unsigned frame_len;
  logic [15:0] crc_acc;
  logic [7:0]  id_byte;
  logic [7:0]  func_byte;
  logic [7:0]  exc_byte;
  logic [31:0] echo;
  logic [7:0]  crc_lo;

  initial begin
    failures        = 0;
    awaiting        = 0;
    data_bytes_seen = 0;
    status_tally    = '0;
  end

  // Reflected CRC-16 step, one byte at a time
  function automatic logic [15:0] crc_step(logic [15:0] acc, logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic start_frame();
    pos       = 0;
    frame_len = MIN_FRAME_LEN;
    crc_acc   = CRC_INIT;
    echo      = '0;
  endtask

  // Verdict on the last byte: CRC first, then exception, then address, function and echo checks
  function automatic mrc_status_t judge_frame(logic [7:0] crc_hi, output logic [7:0] code);
    code = '0;
    if ({crc_hi, crc_lo} != crc_acc) return STATUS_CRC_ERROR;
    if ((func_byte & EXC_FLAG_MASK) != 8'h00) begin
      if (exc_byte == 8'h00) return STATUS_MISMATCH;
      code = exc_byte;
      return STATUS_EXCEPTION;
    end
    if (id_byte != shadow.slave_address) return STATUS_MISMATCH;
    if (shadow.write_mode) begin
      if (func_byte != FUNC_WRITE_MULTIPLE) return STATUS_MISMATCH;
      if (echo[31:16] != shadow.expected_start) return STATUS_MISMATCH;
      if (echo[15:0] != {9'd0, shadow.expected_quantity}) return STATUS_MISMATCH;
      if (shadow.expected_quantity > MAX_REGS) return STATUS_MISMATCH;
      return STATUS_OK;
    end
    if (func_byte != FUNC_READ_HOLDING) return STATUS_MISMATCH;
    return STATUS_OK;
  endfunction

  // Work out what one accepted byte should produce
  task automatic predict_byte(logic [7:0] b, logic restart);
    frame_result_t r;
    logic [7:0]    code;
    bit            emit;
    bit            is_exc;
    r    = '0;
    emit = 1'b0;
    if (restart) start_frame();
    if (pos + 2 < frame_len) begin
      crc_acc = crc_step(crc_acc, b);
      if (pos == 0) id_byte = b;
      else if (pos == 1) func_byte = b;
      is_exc = (func_byte & EXC_FLAG_MASK) != 8'h00;
      if (pos == 2) begin
        if (is_exc) begin
          exc_byte  = b;
          frame_len = MIN_FRAME_LEN;
        end else if (shadow.write_mode) begin
          frame_len = WRITE_FRAME_LEN;
        end else begin
          frame_len = MIN_FRAME_LEN + b;
        end
      end
      if (pos >= 2 && pos <= 5) echo = {echo[23:0], b};
      // read data goes out before the frame is validated
      if (pos >= 3 && !shadow.write_mode && !is_exc) begin
        r.kind    = KIND_DATA;
        r.payload = b;
        emit      = 1'b1;
      end
      pos++;
    end else if (pos + 2 == frame_len) begin
      crc_lo = b;
      pos++;
    end else begin
      r.kind   = KIND_STATUS;
      r.status = judge_frame(b, code);
      r.code   = code;
      emit     = 1'b1;
      start_frame();
    end
    if (emit) awaited_results.push_back(r);
  endtask

  task automatic log_failure(bit unexpected, frame_result_t want, frame_result_t got);
    failures++;
    if (failures <= 10) begin
      if (unexpected)
        $display("frame check @%0t: unexpected result kind %0d payload %02h status %0d code %02h",
                 $time, got.kind, got.payload, got.status, got.code);
      else
        $display("frame check @%0t: expected kind %0d payload %02h status %0d code %02h, got kind %0d payload %02h status %0d code %02h",
                 $time, want.kind, want.payload, want.status, want.code,
                 got.kind, got.payload, got.status, got.code);
    end
  endtask

  // Compare a returned result with the oldest prediction
  task automatic check_result();
    frame_result_t got;
    frame_result_t want;
    got = {res.kind, res.payload, res.status, res.exception_code};
    if (awaited_results.size() == 0) begin
      log_failure(1'b1, '0, got);
    end else begin
      want = awaited_results.pop_front();
      if (got.kind !== want.kind || got.payload !== want.payload ||
          got.status !== want.status || got.code !== want.code)
        log_failure(1'b0, want, got);
      if (want.kind == KIND_STATUS) status_tally[want.status]++;
      else data_bytes_seen++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shadow.slave_address     = 8'd1;
      shadow.write_mode        = 1'b0;
      shadow.expected_start    = '0;
      shadow.expected_quantity = '0;
      start_frame();
      id_byte   = '0;
      func_byte = '0;
      exc_byte  = '0;
      crc_lo    = '0;
      awaited_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (mrc_reg_idx_t'(cfg.index))
          REG_SLAVE_ADDRESS:     shadow.slave_address     = cfg.data[7:0];
          REG_WRITE_MODE:        shadow.write_mode        = cfg.data[0];
          REG_EXPECTED_START:    shadow.expected_start    = cfg.data;
          REG_EXPECTED_QUANTITY: shadow.expected_quantity = cfg.data[6:0];
          default: ;
        endcase
      end
      if (rx.valid && rx.ready) predict_byte(rx.rx_byte, rx.restart);
      if (res.valid && res.ready) check_result();
    end
    awaiting = awaited_results.size();
  end

endmodule

### verif/tb_modbus_rtu_response_checker.sv
// Testbench top for the Modbus RTU response checker.
// Drives response frames, good and damaged, plus register setups; the verdict
// comes from mrc_frame_checker. Depends on mrc_pkg, mrc_if, mrc_frame_checker and the block.
module tb_modbus_rtu_response_checker;
  import mrc_pkg::*;

  localparam int unsigned RANDOM_BYTES  = 450;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  typedef enum {
    FR_GOOD, FR_EXCEPTION, FR_BAD_ID, FR_BAD_FUNC, FR_BAD_ECHO,
    FR_BAD_CRC, FR_TRUNCATED, FR_NOISE
  } frame_shape_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  mrc_in_if  rx ();
  mrc_out_if res ();
  mrc_cfg_if cfg ();

  int unsigned      failures;
  int unsigned      awaiting;
  int unsigned      data_bytes_seen;
  logic [3:0][31:0] status_tally;

  modbus_rtu_response_checker dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .res (res),
    .cfg (cfg)
  );

  mrc_frame_checker frame_check (
    .clk             (clk),
    .rst             (rst),
    .rx              (rx),
    .res             (res),
    .cfg             (cfg),
    .failures        (failures),
    .awaiting        (awaiting),
    .data_bytes_seen (data_bytes_seen),
    .status_tally    (status_tally)
  );

  mrc_cfg_t    cfg_now;
  logic [7:0]  frame_buf [$];
  int unsigned bytes_sent = 0;
  int unsigned setups = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on = 1'b1;

  // Result side stalls at random while gaps are on
  always @(posedge clk) begin
    res.ready <= !gaps_on || ($urandom_range(99) >= 34);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycle_count, awaiting);
      $display("TB_ERROR");
      $finish;
    end
  end

  // One byte request; valid stays high into the next call unless it idles
  task automatic send_byte(logic [7:0] b, logic restart);
    while (gaps_on && $urandom_range(99) < 34) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    rx.restart <= restart;
    do @(posedge clk); while (!rx.ready);
    bytes_sent++;
  endtask

  // Hold off until every predicted result is back and the pipe is empty
  task automatic settle();
    rx.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(mrc_reg_idx_t idx, logic [15:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
  endtask

  // Writes all four registers; unused upper data bits carry junk
  task automatic program_registers(logic [7:0] slave, logic mode, logic [15:0] start,
                                   logic [6:0] qty);
    put_reg(REG_SLAVE_ADDRESS, {8'($urandom), slave});
    put_reg(REG_WRITE_MODE, {15'($urandom), mode});
    put_reg(REG_EXPECTED_START, start);
    put_reg(REG_EXPECTED_QUANTITY, {9'($urandom), qty});
    cfg.valid <= 1'b0;
    cfg_now.slave_address     = slave;
    cfg_now.write_mode        = mode;
    cfg_now.expected_start    = start;
    cfg_now.expected_quantity = qty;
    setups++;
  endtask

  function automatic int unsigned pick(int unsigned lo, int unsigned hi);
    case ($urandom_range(3))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  task automatic reprogram_random();
    logic [6:0] qty;
    qty = 7'(pick(0, 127));
    // the boundary around the largest legal quantity
    if ($urandom_range(4) == 0) qty = 7'(MAX_REGS + $urandom_range(1));
    program_registers(8'(pick(0, 255)), 1'($urandom_range(1)), 16'(pick(0, 65535)), qty);
  endtask

  task automatic seal_frame();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_buf[i]) c = crc16_byte(c, frame_buf[i]);
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
  endtask

  // Builds a response for the current setup, then damages it as asked
  task automatic compose_frame(frame_shape_t shape, int unsigned count);
    logic [7:0] id;
    logic [7:0] func;
    logic [7:0] code;
    int unsigned k;
    frame_buf.delete();
    id   = cfg_now.slave_address;
    func = cfg_now.write_mode ? FUNC_WRITE_MULTIPLE : FUNC_READ_HOLDING;
    if (shape == FR_BAD_ID || (shape == FR_BAD_ECHO && !cfg_now.write_mode))
      id = id ^ 8'($urandom_range(255, 1));
    if (shape == FR_BAD_FUNC) begin
      do func = 8'($urandom_range(127));
      while (func == (cfg_now.write_mode ? FUNC_WRITE_MULTIPLE : FUNC_READ_HOLDING));
    end
    if (shape == FR_EXCEPTION) begin
      if ($urandom_range(1)) id = 8'($urandom);
      func = EXC_FLAG_MASK | 8'($urandom_range(127));
      case ($urandom_range(7))
        0:       code = 8'h00;
        1:       code = 8'hFF;
        default: code = 8'($urandom);
      endcase
      frame_buf = {id, func, code};
    end else if (cfg_now.write_mode) begin
      frame_buf = {id, func, cfg_now.expected_start[15:8], cfg_now.expected_start[7:0],
                   8'h00, {1'b0, cfg_now.expected_quantity}};
      if (shape == FR_BAD_ECHO) begin
        k = $urandom_range(5, 2);
        frame_buf[k] ^= 8'h01 << $urandom_range(7);
      end
    end else begin
      frame_buf = {id, func, 8'(count)};
      repeat (count) frame_buf.push_back(8'($urandom));
    end
    seal_frame();
    if (shape == FR_BAD_CRC)
      frame_buf[frame_buf.size() - 1 - $urandom_range(1)] ^= 8'h01 << $urandom_range(7);
    if (shape == FR_TRUNCATED)
      repeat ($urandom_range(frame_buf.size() - 1, 1)) void'(frame_buf.pop_back());
  endtask

  // Sends frame_buf; sometimes stops part way to change the setup
  task automatic send_frame(logic fresh, bit may_split, output bit split);
    int unsigned cut;
    cut   = 0;
    split = 1'b0;
    if (may_split && frame_buf.size() > 1 && $urandom_range(99) < 8)
      cut = $urandom_range(frame_buf.size() - 1, 1);
    foreach (frame_buf[i]) begin
      if (cut != 0 && i == cut) begin
        settle();
        reprogram_random();
        split = 1'b1;
      end
      send_byte(frame_buf[i], (i == 0) ? fresh : 1'b0);
    end
  endtask

  initial begin
    frame_shape_t shape;
    int unsigned  roll;
    int unsigned  count;
    int unsigned  first_random;
    bit           in_sync;
    bit           split;
    bit           max_frame_sent;

    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    rx.restart = 1'b0;
    cfg.valid  = 1'b0;
    cfg.index  = REG_SLAVE_ADDRESS;
    cfg.data   = '0;
    res.ready  = 1'b0;
    cfg_now.slave_address     = 8'd1;
    cfg_now.write_mode        = 1'b0;
    cfg_now.expected_start    = '0;
    cfg_now.expected_quantity = '0;
    max_frame_sent = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: read frame with extreme data bytes, reset setup
    frame_buf = {8'h01, FUNC_READ_HOLDING, 8'h02, 8'h00, 8'hFF};
    seal_frame();
    send_frame(1'b1, 1'b0, split);
    // exception frame carrying code zero
    frame_buf = {8'hFF, EXC_FLAG_MASK | FUNC_READ_HOLDING, 8'h00};
    seal_frame();
    send_frame(1'b0, 1'b0, split);
    // partial frame dropped by a restart, then an empty read with a bad trailer
    frame_buf = {8'h01, FUNC_READ_HOLDING};
    send_frame(1'b0, 1'b0, split);
    frame_buf = {8'h01, FUNC_READ_HOLDING, 8'h00};
    seal_frame();
    frame_buf[4] ^= 8'h80;
    send_frame(1'b1, 1'b0, split);
    // write echo that matches, but with a quantity no request can carry
    settle();
    program_registers(8'hFF, 1'b1, 16'hFFFF, 7'd127);
    frame_buf = {8'hFF, FUNC_WRITE_MULTIPLE, 8'hFF, 8'hFF, 8'h00, 8'h7F};
    seal_frame();
    send_frame(1'b1, 1'b0, split);

    // Random frames, mostly well formed
    in_sync      = 1'b1;
    first_random = bytes_sent;
    while (bytes_sent - first_random < RANDOM_BYTES) begin
      // a quiet stretch with no stalls on either side
      gaps_on = !(bytes_sent - first_random >= 150 && bytes_sent - first_random < 230);
      if ($urandom_range(99) < 5) begin
        settle();
        reprogram_random();
      end
      if (!max_frame_sent && bytes_sent - first_random >= 300) begin
        // the longest read response the byte count allows
        settle();
        program_registers(cfg_now.slave_address, 1'b0, cfg_now.expected_start,
                          cfg_now.expected_quantity);
        compose_frame(FR_GOOD, 255);
        send_frame(1'b1, 1'b0, split);
        max_frame_sent = 1'b1;
        in_sync        = 1'b1;
        continue;
      end
      roll = $urandom_range(99);
      if (roll < 45)      shape = FR_GOOD;
      else if (roll < 57) shape = FR_EXCEPTION;
      else if (roll < 64) shape = FR_BAD_ID;
      else if (roll < 71) shape = FR_BAD_FUNC;
      else if (roll < 78) shape = FR_BAD_ECHO;
      else if (roll < 86) shape = FR_BAD_CRC;
      else if (roll < 93) shape = FR_TRUNCATED;
      else                shape = FR_NOISE;
      if (shape == FR_NOISE) begin
        repeat ($urandom_range(12, 1)) send_byte(8'($urandom), $urandom_range(99) < 15);
        in_sync = 1'b0;
      end else begin
        count = ($urandom_range(99) < 4) ? $urandom_range(60, 9) : $urandom_range(8);
        compose_frame(shape, count);
        send_frame(in_sync ? 1'($urandom_range(1)) : 1'b1, 1'b1, split);
        in_sync = (shape != FR_TRUNCATED) && !split;
      end
    end

    // Drain and give the verdict
    rx.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    $display("Covered %0d response bytes across %0d register setups, %0d data bytes returned.",
             bytes_sent, setups, data_bytes_seen);
    $display("Frame verdicts: %0d ok, %0d exception, %0d mismatch, %0d crc error; %0d failures.",
             status_tally[STATUS_OK], status_tally[STATUS_EXCEPTION],
             status_tally[STATUS_MISMATCH], status_tally[STATUS_CRC_ERROR], failures);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
